FILE: rtl/core/mfpe_pkg.sv
// shared constants and types for the mono framebuffer pixel expander
`timescale 1ns / 1ps

package mfpe_pkg;

  // framebuffer store
  localparam int FRAME_WORDS = 32768;
  localparam int FB_AW       = $clog2(FRAME_WORDS);
  localparam int FB_DW       = 32;

  // field widths
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 12;
  localparam int SRCB_W    = 18;
  localparam int WIDX_W    = 15;
  localparam int PIX_W     = 11;
  localparam int ARGB_W    = 32;
  localparam int DOFF_W    = 24;
  localparam int STRIDE_W  = 10;
  localparam int PROD_W    = 22;

  // channel packing
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SRCB   = 3'd2;
  localparam logic [2:0] REG_LSB    = 3'd3;
  localparam logic [2:0] REG_BOTUP  = 3'd4;

  // register reset values
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

  // item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  // colours
  localparam logic [ARGB_W-1:0] WHITE_PIX = 32'hFFFF_FFFF;
  localparam logic [ARGB_W-1:0] BLACK_PIX = 32'hFF00_0000;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [SRCB_W-1:0]   src_bytes;
    logic                lsb_first;
    logic                bottom_up;
  } cfg_t;

endpackage

FILE: rtl/core/mfpe_ram.sv
// single-port-write, single-port-read word store with registered read data
`timescale 1ns / 1ps

module mfpe_ram #(
  parameter int DEPTH = 32768,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/mfpe_cfg.sv
// apb register block for screen geometry and layout selection
`timescale 1ns / 1ps

module mfpe_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mfpe_pkg::CFG_AW-1:0]  paddr,
  input  logic [mfpe_pkg::CFG_DW-1:0]  pwdata,
  output logic [mfpe_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output mfpe_pkg::cfg_t               cfg
);

  mfpe_pkg::cfg_t cfg_r;
  mfpe_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        mfpe_pkg::REG_WIDTH:  cfg_nxt.width     = pwdata[mfpe_pkg::WIDTH_W-1:0];
        mfpe_pkg::REG_HEIGHT: cfg_nxt.height    = pwdata[mfpe_pkg::HEIGHT_W-1:0];
        mfpe_pkg::REG_SRCB:   cfg_nxt.src_bytes = pwdata[mfpe_pkg::SRCB_W-1:0];
        mfpe_pkg::REG_LSB:    cfg_nxt.lsb_first = pwdata[0];
        mfpe_pkg::REG_BOTUP:  cfg_nxt.bottom_up = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= mfpe_pkg::WIDTH_RST;
      cfg_r.height    <= mfpe_pkg::HEIGHT_RST;
      cfg_r.src_bytes <= '0;
      cfg_r.lsb_first <= 1'b0;
      cfg_r.bottom_up <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      mfpe_pkg::REG_WIDTH:  prdata = 32'(cfg_r.width);
      mfpe_pkg::REG_HEIGHT: prdata = 32'(cfg_r.height);
      mfpe_pkg::REG_SRCB:   prdata = 32'(cfg_r.src_bytes);
      mfpe_pkg::REG_LSB:    prdata = 32'(cfg_r.lsb_first);
      mfpe_pkg::REG_BOTUP:  prdata = 32'(cfg_r.bottom_up);
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/mono_framebuffer_pixel_expand.sv
// top level: 1bpp framebuffer store and pixel expansion to argb8888
`timescale 1ns / 1ps

// Holds a one-bit-per-pixel framebuffer of 32768 words and expands single pixels to
// ARGB8888 on request. A write transaction (in_tuser = 0) stores one word, so writes may
// follow each other on every clock while no render is in progress. A render transaction
// (in_tuser = 1) occupies the block through acceptance, a multiply stage for row limit,
// row base and destination offset, an address stage that issues the memory read, and a
// read-data stage for the registered read data from the single-read-port store; the next
// item is taken in the cycle after that stage. The result goes into an output register;
// while an earlier result still waits there untaken, a render stays in its read-data
// stage until the register frees, and the input is held off for that time. Invalid pixels
// (row past the usable data, x past the width, zero stride, MSB byte past the stride)
// come out with out_tuser = 0 and zero payload. The store has no reset and no clearing
// pass: render only words that have been written. Change the registers only while idle.

module mono_framebuffer_pixel_expand (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, from bit 0: word_index[14:0], word_value[31:0], pixel_x[10:0],
  // pixel_y[10:0], zero fill
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mfpe_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: action (0 write word, 1 render pixel)
  input  logic                               in_tuser,
  // out_tdata, from bit 0: argb_colour[31:0], dest_offset[23:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mfpe_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: pixel_valid
  output logic                               out_tuser,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mfpe_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [mfpe_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [mfpe_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  mfpe_pkg::cfg_t cfg;

  // sequencer
  logic [1:0] state_r, state_nxt;
  logic       in_acc;
  logic       out_load;

  // input fields
  logic [mfpe_pkg::WIDX_W-1:0] in_widx;
  logic [mfpe_pkg::FB_DW-1:0]  in_wval;
  logic [mfpe_pkg::PIX_W-1:0]  in_px;
  logic [mfpe_pkg::PIX_W-1:0]  in_py;

  // item registers
  logic [mfpe_pkg::PIX_W-1:0]  px_r;
  logic [mfpe_pkg::PIX_W-1:0]  py_r;

  // geometry
  logic [mfpe_pkg::WIDTH_W:0]    w_round;
  logic [mfpe_pkg::STRIDE_W-1:0] stride;
  logic [mfpe_pkg::HEIGHT_W-1:0] y_p1;
  logic [mfpe_pkg::HEIGHT_W-1:0] src_row;
  logic                          pre_ok;

  // multiply stage results
  logic [mfpe_pkg::PROD_W-1:0] row_lim_r;
  logic [mfpe_pkg::PROD_W-1:0] row_base_r;
  logic [mfpe_pkg::PROD_W:0]   yw_r;
  logic                        pre_ok_r;

  // address stage
  logic [mfpe_pkg::PROD_W-1:0] byte_off;
  logic [mfpe_pkg::PROD_W-1:0] byte_addr;
  logic                        rd_en;
  logic [1:0]                  bsel_r;
  logic                        valid_r;
  logic [mfpe_pkg::DOFF_W-1:0] doff_r;
  logic [mfpe_pkg::PROD_W:0]   yw_x;

  // read stage
  logic [mfpe_pkg::FB_DW-1:0]  rdata;
  logic [4:0]                  bit_idx;
  logic                        pix_bit;
  logic [mfpe_pkg::ARGB_W-1:0] colour;

  // output register
  logic                        out_valid_r;
  logic [mfpe_pkg::ARGB_W-1:0] out_argb_r;
  logic [mfpe_pkg::DOFF_W-1:0] out_doff_r;
  logic                        out_pv_r;

  mfpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_widx = in_tdata[14:0];
  assign in_wval = in_tdata[46:15];
  assign in_px   = in_tdata[57:47];
  assign in_py   = in_tdata[68:58];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // width rounded up to whole 16-pixel units for the msb-first layout
  assign w_round = {1'b0, cfg.width} + 13'd15;

  // line stride in bytes for the selected layout
  always_comb begin
    if (cfg.lsb_first) begin
      stride = {1'b0, cfg.width[11:5], 2'b00};
    end else begin
      stride = {w_round[12:4], 1'b0};
    end
  end

  // the row limit y < source_bytes / stride is tested as (y + 1) * stride <= source_bytes
  assign y_p1    = {1'b0, py_r} + 12'd1;
  assign src_row = cfg.bottom_up ? (cfg.height - 12'd1 - {1'b0, py_r}) : {1'b0, py_r};
  assign pre_ok  = ({1'b0, px_r} < cfg.width) && ({1'b0, py_r} < cfg.height) &&
                   (stride != '0) &&
                   (cfg.lsb_first || ({2'b00, px_r[10:3]} < stride));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_px;
      py_r <= in_py;
    end
    if (state_r == ST_MUL) begin
      row_lim_r  <= mfpe_pkg::PROD_W'(y_p1) * mfpe_pkg::PROD_W'(stride);
      row_base_r <= mfpe_pkg::PROD_W'(src_row) * mfpe_pkg::PROD_W'(stride);
      yw_r       <= (mfpe_pkg::PROD_W+1)'(py_r) * (mfpe_pkg::PROD_W+1)'(cfg.width);
      pre_ok_r   <= pre_ok;
    end
  end

  // byte offset within the line: whole 32-bit words for lsb-first, bytes for msb-first
  assign byte_off  = cfg.lsb_first ? mfpe_pkg::PROD_W'({px_r[10:5], 2'b00})
                                   : mfpe_pkg::PROD_W'(px_r[10:3]);
  assign byte_addr = row_base_r + byte_off;
  assign rd_en     = (state_r == ST_ADDR);
  assign yw_x      = yw_r + (mfpe_pkg::PROD_W+1)'(px_r);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      bsel_r  <= byte_addr[1:0];
      valid_r <= pre_ok_r && (row_lim_r <= mfpe_pkg::PROD_W'(cfg.src_bytes));
      doff_r  <= {yw_x[mfpe_pkg::DOFF_W-3:0], 2'b00};
    end
  end

  mfpe_ram #(
    .DEPTH (mfpe_pkg::FRAME_WORDS),
    .DW    (mfpe_pkg::FB_DW)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc && (in_tuser == mfpe_pkg::ACT_WRITE)),
    .waddr (in_widx[mfpe_pkg::FB_AW-1:0]),
    .wdata (in_wval),
    .re    (rd_en),
    .raddr (byte_addr[mfpe_pkg::FB_AW+1:2]),
    .rdata (rdata)
  );

  // bit select: lsb-first takes word bit x[4:0], msb-first bit 7 - x[2:0] within the byte
  assign bit_idx = cfg.lsb_first ? px_r[4:0] : {bsel_r, 3'b111 - px_r[2:0]};
  assign pix_bit = rdata[bit_idx];

  always_comb begin
    if (cfg.lsb_first) begin
      colour = pix_bit ? mfpe_pkg::WHITE_PIX : mfpe_pkg::BLACK_PIX;
    end else begin
      colour = pix_bit ? mfpe_pkg::BLACK_PIX : mfpe_pkg::WHITE_PIX;
    end
  end

  assign out_load = (state_r == ST_READ) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == mfpe_pkg::ACT_RENDER)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // invalid pixels carry zero colour and offset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_argb_r <= valid_r ? colour : '0;
      out_doff_r <= valid_r ? doff_r : '0;
      out_pv_r   <= valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_doff_r, out_argb_r};
  assign out_tuser  = out_pv_r;

`ifndef SYNTH
  // a write transaction never starts the render sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == mfpe_pkg::ACT_WRITE)) |=> (state_r == ST_IDLE))
    else $error("write transaction left the idle state");

  // a memory read is always followed by the read-data cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == ST_READ))
    else $error("memory read not followed by read stage");

  // a skipped pixel leaves the payload all zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("invalid pixel with non-zero payload");

  // a rendered pixel is either white or black
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ((out_argb_r == mfpe_pkg::WHITE_PIX) || (out_argb_r == mfpe_pkg::BLACK_PIX)))
    else $error("rendered pixel colour is neither white nor black");
`endif

endmodule

FILE: bench/tb_mono_framebuffer_pixel_expand.sv
// self-checking bench for the 1bpp framebuffer pixel expander, with shadow store and predictor
`timescale 1ns / 1ps

module tb_mono_framebuffer_pixel_expand;
  import mfpe_pkg::*;

  // quiet cycles before the watchdog gives up
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_DIM       = 2048;
  localparam int unsigned MAX_SRC_BYTES = 131072;

  typedef struct packed {
    logic [ARGB_W-1:0] colour;
    logic [DOFF_W-1:0] offset;
    logic              valid;
  } pixel_result_t;

  // where a render reads the store: word address and bit within the word
  typedef struct packed {
    logic              hit;
    logic [FB_AW-1:0]  waddr;
    logic [4:0]        bitpos;
  } pixel_loc_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = ACT_WRITE;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // shadow copies of the block's registers and framebuffer
  cfg_t              shadow_cfg;
  logic [FB_DW-1:0]  fb_shadow  [FRAME_WORDS];
  bit                fb_written [FRAME_WORDS];

  pixel_result_t     expected_pixels [$];
  int unsigned       mismatches  = 0;
  int unsigned       items_sent  = 0;
  int unsigned       quiet_cycles = 0;
  bit                no_idle     = 1'b0;

  mono_framebuffer_pixel_expand DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // bytes per source line for the current layout
  function automatic int unsigned line_stride();
    int unsigned w;
    w = shadow_cfg.width;
    if (shadow_cfg.lsb_first) return (w / 32) * 4;
    return ((w + 15) / 16) * 2;
  endfunction

  // rows backed by valid data, never more than the screen height
  function automatic int unsigned usable_rows();
    int unsigned stride;
    int unsigned rows;
    stride = line_stride();
    rows = (stride == 0) ? 0 : shadow_cfg.src_bytes / stride;
    if (rows > shadow_cfg.height) rows = shadow_cfg.height;
    return rows;
  endfunction

  // work out which store bit a screen pixel comes from, if any
  function automatic pixel_loc_t locate_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    pixel_loc_t  loc;
    int unsigned x;
    int unsigned y;
    int unsigned stride;
    int unsigned src_row;
    int unsigned base;
    loc = '0;
    x = px;
    y = py;
    stride = line_stride();
    // the row test is on the screen row, also when flipped
    if (y < usable_rows() && x < shadow_cfg.width) begin
      src_row = shadow_cfg.bottom_up ? (int'(shadow_cfg.height) - 1 - y) : y;
      if (shadow_cfg.lsb_first) begin
        // a word past the stride is still read: it is the next line's
        base = stride * src_row + 4 * (x / 32);
        loc.hit = 1'b1;
        loc.waddr = FB_AW'(base >> 2);
        loc.bitpos = 5'(x % 32);
      end else if ((x >> 3) < stride) begin
        base = stride * src_row + (x >> 3);
        loc.hit = 1'b1;
        loc.waddr = FB_AW'(base >> 2);
        loc.bitpos = 5'(8 * (base & 3) + 7 - (x & 7));
      end
    end
    return loc;
  endfunction

  // expected colour, offset and valid flag for one render
  function automatic pixel_result_t expand_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    pixel_result_t res;
    pixel_loc_t    loc;
    logic          bit_val;
    int unsigned   lin;
    res = '0;
    loc = locate_pixel(px, py);
    if (loc.hit) begin
      bit_val = fb_shadow[loc.waddr][loc.bitpos];
      // lsb-first: 1 is white; msb-first: 1 is black
      if (shadow_cfg.lsb_first) res.colour = bit_val ? WHITE_PIX : BLACK_PIX;
      else                      res.colour = bit_val ? BLACK_PIX : WHITE_PIX;
      lin = (int'(py) * int'(shadow_cfg.width) + int'(px)) * 4;
      res.offset = DOFF_W'(lin);
      res.valid = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input channel
  // ---------------------------------------------------------------------------

  // offer one transaction, wait for it to be taken, then maybe idle
  task automatic push_item(input logic act, input logic [WIDX_W-1:0] widx,
                           input logic [FB_DW-1:0] wval,
                           input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    int unsigned gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = {{(IN_TDATA_W - 2 * PIX_W - FB_DW - WIDX_W){1'b0}}, py, px, wval, widx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (act == ACT_WRITE) begin
      fb_shadow[widx] = wval;
      fb_written[widx] = 1'b1;
    end else begin
      expected_pixels.push_back(expand_pixel(px, py));
    end
    // gap of zero keeps tvalid high for the next transaction
    gap = idle_len();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // pixel fields are unused on a write, so they carry noise
  task automatic write_word(input logic [WIDX_W-1:0] widx, input logic [FB_DW-1:0] wval);
    push_item(ACT_WRITE, widx, wval, PIX_W'($urandom), PIX_W'($urandom));
  endtask

  // render a pixel, first filling its word if it has never been written
  task automatic render_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    pixel_loc_t loc;
    loc = locate_pixel(px, py);
    if (loc.hit && !fb_written[loc.waddr]) write_word(loc.waddr, $urandom);
    push_item(ACT_RENDER, WIDX_W'($urandom), $urandom, px, py);
  endtask

  // stop sending and wait for every outstanding result plus the pipeline tail
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  // write one register, then read it back through a back-to-back access
  task automatic program_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] got;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_WIDTH:  shadow_cfg.width     = value[WIDTH_W-1:0];
      REG_HEIGHT: shadow_cfg.height    = value[HEIGHT_W-1:0];
      REG_SRCB:   shadow_cfg.src_bytes = value[SRCB_W-1:0];
      REG_LSB:    shadow_cfg.lsb_first = value[0];
      REG_BOTUP:  shadow_cfg.bottom_up = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    if (got !== value) begin
      $display("%0t: register %0d read back, expected %h actual %h", $time, idx, value, got);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // registers change only once the block has gone idle
  task automatic apply_config(input int unsigned w, input int unsigned h,
                              input int unsigned src, input bit lsb, input bit bu);
    drain_results();
    program_reg(REG_WIDTH, w);
    program_reg(REG_HEIGHT, h);
    program_reg(REG_SRCB, src);
    program_reg(REG_LSB, lsb);
    program_reg(REG_BOTUP, bu);
  endtask

  // screen dimension: the extremes, a narrow value or anything in range
  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return MAX_DIM;
      2:       return $urandom_range(1, 40);
      default: return $urandom_range(1, MAX_DIM);
    endcase
  endfunction

  task automatic randomise_config();
    int unsigned src;
    case ($urandom_range(0, 5))
      0:       src = 0;
      1:       src = MAX_SRC_BYTES;
      default: src = $urandom_range(0, MAX_SRC_BYTES);
    endcase
    apply_config(pick_dim(), pick_dim(), src, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset settings hold no usable rows, so every pixel is skipped
  task automatic test_reset_state();
    render_pixel(0, 0);
    render_pixel(11'h7FF, 11'h7FF);
  endtask

  // msb-first at the largest screen and buffer, both word extremes
  task automatic test_msb_extremes();
    apply_config(MAX_DIM, MAX_DIM, MAX_SRC_BYTES, 1'b0, 1'b0);
    write_word(0, 32'hFFFF_FFFF);
    write_word(15'h7FFF, 32'h0000_0000);
    render_pixel(0, 0);
    render_pixel(7, 0);
    render_pixel(11'd2047, 0);
    render_pixel(0, 11'd511);
    render_pixel(11'd2047, 11'd511);
    // first row past the buffer length
    render_pixel(0, 11'd512);
  endtask

  // lsb-first with a width that is not a multiple of 32, then a zero stride
  task automatic test_lsb_layout();
    apply_config(40, 3, 12, 1'b1, 1'b0);
    write_word(0, 32'h0000_0001);
    render_pixel(0, 0);
    render_pixel(1, 0);
    // word past the stride belongs to the next line
    render_pixel(35, 1);
    render_pixel(39, 2);
    render_pixel(40, 0);
    render_pixel(0, 3);
    // below 32 pixels the lsb-first stride is zero
    apply_config(31, 3, 12, 1'b1, 1'b0);
    render_pixel(0, 0);
  endtask

  // flipped rows land far past the store and wrap round the word addresses
  task automatic test_bottom_up_wrap();
    apply_config(MAX_DIM, MAX_DIM, MAX_SRC_BYTES, 1'b0, 1'b1);
    render_pixel(0, 0);
    render_pixel(11'd2047, 11'd511);
    // row limit uses the screen row, not the flipped source row
    render_pixel(0, 11'd512);
  endtask

  // one-pixel screen; with msb-first the stride always covers the width,
  // so the byte-past-stride case can never be reached from valid fields
  task automatic test_tiny_screen();
    apply_config(1, 1, 2, 1'b0, 1'b0);
    render_pixel(0, 0);
    render_pixel(1, 0);
    render_pixel(0, 1);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic
  // ---------------------------------------------------------------------------

  // mostly in-area renders and writes into the live area, the rest noise;
  // halfway through the sender holds off until all results are back
  task automatic run_random_phase(input int unsigned budget);
    int unsigned      start;
    int unsigned      rows;
    int unsigned      roll;
    bit               paused;
    pixel_loc_t       loc;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    start = items_sent;
    rows = usable_rows();
    paused = 1'b0;
    while (items_sent - start < budget) begin
      if (!paused && items_sent - start >= budget / 2) begin
        drain_results();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (rows != 0 && roll < 60) begin
        px = PIX_W'($urandom_range(0, int'(shadow_cfg.width) - 1));
        py = PIX_W'($urandom_range(0, rows - 1));
      end else begin
        px = PIX_W'($urandom);
        py = PIX_W'($urandom);
      end
      if (roll < 45 || (roll >= 60 && roll < 75)) begin
        render_pixel(px, py);
      end else if (roll < 60) begin
        // overwrite a word that in-area pixels read
        loc = locate_pixel(px, py);
        if (loc.hit) write_word(loc.waddr, $urandom);
        else         write_word(WIDX_W'($urandom), $urandom);
      end else begin
        write_word(WIDX_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_random_traffic();
    apply_config(MAX_DIM, MAX_DIM, MAX_SRC_BYTES, 1'b0, 1'b1);
    run_random_phase(300);
    apply_config(MAX_DIM, MAX_DIM, MAX_SRC_BYTES, 1'b1, 1'b0);
    run_random_phase(300);
    // back-to-back transactions on both sides
    randomise_config();
    no_idle = 1'b1;
    run_random_phase(300);
    no_idle = 1'b0;
    repeat (3) begin
      randomise_config();
      run_random_phase(320);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver back-pressure, stalls mostly short with some long ones
  always begin : sink_pacing
    int unsigned hold;
    @(negedge clk);
    hold = idle_len();
    if (hold != 0) begin
      out_tready = 1'b0;
      repeat (hold) @(negedge clk);
    end
    out_tready = 1'b1;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h/%b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[ARGB_W-1:0] !== want.colour) begin
          $display("%0t: argb_colour, expected %h actual %h",
                   $time, want.colour, out_tdata[ARGB_W-1:0]);
          mismatches++;
        end
        if (out_tdata[ARGB_W +: DOFF_W] !== want.offset) begin
          $display("%0t: dest_offset, expected %h actual %h",
                   $time, want.offset, out_tdata[ARGB_W +: DOFF_W]);
          mismatches++;
        end
        if (out_tuser !== want.valid) begin
          $display("%0t: pixel_valid, expected %b actual %b", $time, want.valid, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // end the run if no transaction moves on any port for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, expected_pixels.size());
      $display("tb_mono_framebuffer_pixel_expand: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    shadow_cfg = '{width: WIDTH_RST, height: HEIGHT_RST, src_bytes: '0,
                   lsb_first: 1'b0, bottom_up: 1'b0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_msb_extremes();
    test_lsb_layout();
    test_bottom_up_wrap();
    test_tiny_screen();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("tb_mono_framebuffer_pixel_expand: PASS");
    end else begin
      $display("tb_mono_framebuffer_pixel_expand: FAIL");
    end
    $finish;
  end

endmodule
